### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/bcd_mup_pkg.sv
package bcd_mup_pkg;

   localparam int ID_SKIP_DEFAULT = 20;
   localparam int FIXED_TAIL      = 6;
   localparam int SEQ_BYTES       = 5;
   localparam int ENTRY_BYTES     = 13;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 136;
   localparam int SEQ_W      = 34;
   localparam int COUNT_W    = 7;
   localparam int PRICE_W    = 30;
   localparam int QTY_W      = 27;
   localparam int LEN_W      = 16;

   // byte offsets inside one entry
   localparam logic [3:0] BIE_ACTION      = 4'd0;
   localparam logic [3:0] BIE_TYPE        = 4'd1;
   localparam logic [3:0] BIE_SIGN        = 4'd2;
   localparam logic [3:0] BIE_PRICE_FIRST = 4'd3;
   localparam logic [3:0] BIE_PRICE_LAST  = 4'd7;
   localparam logic [3:0] BIE_QTY_FIRST   = 4'd8;
   localparam logic [3:0] BIE_QTY_LAST    = 4'd11;

   typedef enum logic [1:0] {
      KIND_HEADER,
      KIND_ENTRY,
      KIND_STATUS
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_SHORT_FIXED,
      ST_SHORT_ENTRIES,
      ST_BAD_BCD
   } status_type;

   typedef struct packed {
      kind_type             kind;
      logic [SEQ_W-1:0]     seq_number;
      logic [COUNT_W-1:0]   entry_count;
      logic [7:0]           update_action;
      logic [7:0]           entry_type;
      logic [7:0]           price_sign;
      logic [PRICE_W-1:0]   price;
      logic [QTY_W-1:0]     quantity;
      logic [COUNT_W-1:0]   price_level;
      status_type           status;
      logic                 last;
   } rsp_type;

   function automatic logic bcd_ok(input logic [7:0] b);
      return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
   endfunction

   function automatic logic [6:0] bcd_val(input logic [7:0] b);
      return ({3'b0, b[7:4]} << 3) + ({3'b0, b[7:4]} << 1) + {3'b0, b[3:0]};
   endfunction

   // acc * 100 + two new digits, kept to 34 bits
   function automatic logic [SEQ_W-1:0] acc_step(input logic [SEQ_W-1:0] acc,
                                                 input logic [7:0]       b);
      return (acc << 6) + (acc << 5) + (acc << 2) + SEQ_W'(bcd_val(b));
   endfunction

   function automatic rsp_type status_rsp(input status_type st);
      rsp_type r;
      r        = '0;
      r.kind   = KIND_STATUS;
      r.status = st;
      r.last   = 1'b1;
      return r;
   endfunction

endpackage

### hw/rtl/bcd_market_update_parser_top.sv
// Path: a request is taken into the input register, then its first result into the result
// register. Throughput: one body byte per cycle unless the output stalls; a byte that
// yields two results (last entry or zero-count header plus final status) holds the next
// input byte until the first of its two results has been taken.
// Reset (synchronous, active high) empties both registers and leaves the parser
// idle, waiting for a start-of-body byte.
`include "assert_macros.svh"

module bcd_market_update_parser_top #(
   parameter int ID_SKIP_BYTES = bcd_mup_pkg::ID_SKIP_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] body_byte, [23:8] declared_len
   input  logic [bcd_mup_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] start_of_body
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [33:0] seq_number, [40:34] entry_count, [48:41] update_action,
   // [56:49] entry_type, [64:57] price_sign, [94:65] price, [121:95] quantity,
   // [128:122] price_level, [130:129] status, [135:131] zero
   output logic [bcd_mup_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] kind
   output logic [1:0]                         rsp_tuser,
   output logic                               rsp_tlast
);
   import bcd_mup_pkg::*;

   localparam int POS_W = $clog2(ID_SKIP_BYTES + FIXED_TAIL + 1);
   localparam logic [POS_W-1:0] POS_SEQ   = POS_W'(ID_SKIP_BYTES);
   localparam logic [POS_W-1:0] POS_COUNT = POS_W'(ID_SKIP_BYTES + SEQ_BYTES);
   localparam logic [LEN_W-1:0] MIN_LEN   = LEN_W'(ID_SKIP_BYTES + FIXED_TAIL);

   // input register
   logic              in_vld_ff;
   logic [7:0]        in_byte_ff;
   logic              in_start_ff;
   logic [LEN_W-1:0]  in_len_ff;

   // parse state
   logic               active_ff, active_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic [3:0]         bie_ff, bie_in;
   logic [SEQ_W-1:0]   acc_ff, acc_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [23:0]        ats_ff, ats_in;
   logic [PRICE_W-1:0] price_ff, price_in;
   logic [QTY_W-1:0]   qty_ff, qty_in;

   // result register
   logic    out_vld_ff;
   logic    pend_ff;
   rsp_type rsp_ff;

   logic    advance;
   logic    emit;
   logic    second;
   rsp_type res;
   logic [LEN_W:0] need_len;

   assign advance    = in_vld_ff && (!out_vld_ff || (rsp_tready && !pend_ff));
   assign req_tready = !in_vld_ff || advance;

   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      left_in   = left_ff;
      bie_in    = bie_ff;
      acc_in    = acc_ff;
      len_in    = len_ff;
      ats_in    = ats_ff;
      price_in  = price_ff;
      qty_in    = qty_ff;
      emit      = 1'b0;
      second    = 1'b0;
      res       = '0;
      need_len  = (LEN_W+1)'(MIN_LEN) + (LEN_W+1)'(bcd_val(in_byte_ff)) * (LEN_W+1)'(ENTRY_BYTES);
      if (advance) begin
         if (in_start_ff) begin
            active_in = 1'b1;
            pos_in    = '0;
            left_in   = '0;
            bie_in    = '0;
            acc_in    = '0;
            len_in    = in_len_ff;
            ats_in    = '0;
            price_in  = '0;
            qty_in    = '0;
         end
         priority if (in_start_ff && (in_len_ff < MIN_LEN)) begin
            emit      = 1'b1;
            res       = status_rsp(ST_SHORT_FIXED);
            active_in = 1'b0;
         end else if (!active_in) begin
            emit = 1'b0;
         end else if (pos_in < POS_SEQ) begin
            pos_in = pos_in + POS_W'(1);
         end else if (pos_in < POS_COUNT) begin
            if (!bcd_ok(in_byte_ff)) begin
               emit      = 1'b1;
               res       = status_rsp(ST_BAD_BCD);
               active_in = 1'b0;
            end else begin
               acc_in = acc_step(acc_in, in_byte_ff);
               pos_in = pos_in + POS_W'(1);
            end
         end else if (pos_in == POS_COUNT) begin
            if (!bcd_ok(in_byte_ff)) begin
               emit      = 1'b1;
               res       = status_rsp(ST_BAD_BCD);
               active_in = 1'b0;
            end else if ({1'b0, len_in} < need_len) begin
               emit      = 1'b1;
               res       = status_rsp(ST_SHORT_ENTRIES);
               active_in = 1'b0;
            end else begin
               emit            = 1'b1;
               res.kind        = KIND_HEADER;
               res.seq_number  = acc_in;
               res.entry_count = bcd_val(in_byte_ff);
               pos_in          = pos_in + POS_W'(1);
               left_in         = bcd_val(in_byte_ff);
               bie_in          = '0;
               acc_in          = '0;
               if (left_in == '0) begin
                  second    = 1'b1;
                  active_in = 1'b0;
               end
            end
         end else begin
            priority if (bie_in == BIE_ACTION) begin
               ats_in = {in_byte_ff, 16'b0};
               bie_in = bie_in + 4'd1;
            end else if (bie_in == BIE_TYPE) begin
               ats_in[15:8] = in_byte_ff;
               bie_in       = bie_in + 4'd1;
            end else if (bie_in == BIE_SIGN) begin
               ats_in[7:0] = in_byte_ff;
               bie_in      = bie_in + 4'd1;
            end else if (!bcd_ok(in_byte_ff)) begin
               emit      = 1'b1;
               res       = status_rsp(ST_BAD_BCD);
               active_in = 1'b0;
            end else if (bie_in <= BIE_QTY_LAST) begin
               priority if (bie_in == BIE_PRICE_FIRST) begin
                  acc_in = SEQ_W'(in_byte_ff[3:0]);
               end else if (bie_in == BIE_QTY_FIRST) begin
                  acc_in = SEQ_W'(bcd_val(in_byte_ff));
               end else begin
                  acc_in = acc_step(acc_in, in_byte_ff);
               end
               if (bie_in == BIE_PRICE_LAST) begin
                  price_in = acc_in[PRICE_W-1:0];
               end
               if (bie_in == BIE_QTY_LAST) begin
                  qty_in = acc_in[QTY_W-1:0];
               end
               bie_in = bie_in + 4'd1;
            end else begin
               emit              = 1'b1;
               res.kind          = KIND_ENTRY;
               res.update_action = ats_in[23:16];
               res.entry_type    = ats_in[15:8];
               res.price_sign    = ats_in[7:0];
               res.price         = price_in;
               res.quantity      = qty_in;
               res.price_level   = bcd_val(in_byte_ff);
               bie_in            = '0;
               acc_in            = '0;
               left_in           = left_in - COUNT_W'(1);
               if (left_in == '0) begin
                  second    = 1'b1;
                  active_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata[7:0];
         in_len_ff   <= req_tdata[23:8];
         in_start_ff <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= '0;
         left_ff   <= '0;
         bie_ff    <= '0;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         left_ff   <= left_in;
         bie_ff    <= bie_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      len_ff   <= len_in;
      ats_ff   <= ats_in;
      price_ff <= price_in;
      qty_ff   <= qty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else if (emit) begin
         out_vld_ff <= 1'b1;
         pend_ff    <= second;
      end else if (out_vld_ff && rsp_tready) begin
         out_vld_ff <= pend_ff;
         pend_ff    <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= res;
      end else if (out_vld_ff && rsp_tready && pend_ff) begin
         rsp_ff <= status_rsp(ST_OK);
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {5'b0, rsp_ff.status, rsp_ff.price_level, rsp_ff.quantity,
                        rsp_ff.price, rsp_ff.price_sign, rsp_ff.entry_type,
                        rsp_ff.update_action, rsp_ff.entry_count, rsp_ff.seq_number};

   `ASSERT_IMPL(a_pend_has_result, clock, reset, pend_ff, out_vld_ff)
   `ASSERT_IMPL(a_pend_not_status, clock, reset, pend_ff, rsp_ff.kind != KIND_STATUS)
   `ASSERT_IMPL(a_last_on_status, clock, reset, out_vld_ff, (rsp_ff.kind == KIND_STATUS) == rsp_ff.last)
   `ASSERT_NEXT(a_pend_gives_ok, clock, reset, out_vld_ff && pend_ff && rsp_tready, out_vld_ff && rsp_ff.kind == KIND_STATUS && rsp_ff.status == ST_OK)

endmodule
